/* rtl/urz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urz_pkg
// Shared widths, register indexes, zone codes and types for the ultrasonic
// range averaging and zoning block.
// ----------------------------------------------------------------------------
package urz_pkg;

    localparam int MAX_PAIRS  = 16;
    localparam int TICK_WIDTH = 16;

    localparam int LIMIT_W    = 12;
    localparam int PPB_W      = 5;
    localparam int DIST_W     = 12;
    localparam int FAILOUT_W  = 5;
    localparam int ZONE_W     = 2;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // pair and fail counters must hold MAX_PAIRS itself
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    // largest sum: every pair good with both widths one below the top limit
    localparam int SUM_W  = $clog2(MAX_PAIRS * 2 * ((1 << LIMIT_W) - 1) + 1);
    // divisor is twice the good pair count
    localparam int DIV_W  = $clog2(2 * MAX_PAIRS + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int CMP_W  = (TICK_WIDTH > LIMIT_W) ? TICK_WIDTH : LIMIT_W;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS_PER_BURST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_LIMIT      = 3'd4;

    // register reset values
    localparam logic [PPB_W-1:0]   RST_PAIRS_PER_BURST = 5'd10;
    localparam logic [LIMIT_W-1:0] RST_FAIL_LIMIT      = 12'd600;
    localparam logic [LIMIT_W-1:0] RST_NEAR_LIMIT      = 12'd30;
    localparam logic [LIMIT_W-1:0] RST_STOP_LIMIT      = 12'd50;
    localparam logic [LIMIT_W-1:0] RST_SLOW_LIMIT      = 12'd100;

    // zones
    localparam logic [ZONE_W-1:0] ZONE_NEAR  = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_STOP  = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_SLOW  = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_CLEAR = 2'd3;

    // drive commands
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLOW = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GO   = 2'd2;

    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [CMD_W-1:0]  cmd;
        logic              red;
        logic              green;
    } t_zone_res;

endpackage

/* rtl/ultrasonic_range_average_zoner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_average_zoner
// Averages bursts of echo pairs from two sensors and reports distance, zone,
// drive command and LED levels once per burst.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_echo_ticks_a, i_echo_ticks_b
//  out      | source    | o_out_valid/ i_out_stall| distance, zone, command, LEDs,
//           |           |                         | failed pairs, all-failed flag
//  cfg      | sink      | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  A pair inside a burst is taken without a stall. After the last pair of a
//  burst the divider retires one quotient bit per cycle through one
//  subtractor, then the zone step classifies the result.
//  A burst with no good pair skips the divider.
//  Synchronous active-low reset clears counters, sums, LED levels and
//  registers to their defaults. The result register frees the input side:
//  the next burst fills while a result waits; only a second finished burst
//  holds in the zone step until the first beat is taken.
// ----------------------------------------------------------------------------
module ultrasonic_range_average_zoner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [urz_pkg::TICK_WIDTH-1:0]    i_echo_ticks_a,
    input  logic [urz_pkg::TICK_WIDTH-1:0]    i_echo_ticks_b,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [urz_pkg::DIST_W-1:0]        o_distance_cm,
    output logic [urz_pkg::ZONE_W-1:0]        o_zone,
    output logic [urz_pkg::CMD_W-1:0]         o_drive_command,
    output logic                              o_red_led,
    output logic                              o_green_led,
    output logic [urz_pkg::FAILOUT_W-1:0]     o_failed_pairs,
    output logic                              o_all_failed,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [urz_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [urz_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import urz_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_ZONE = 2'd2;

    // configuration
    logic [PPB_W-1:0]   r_ppb;
    logic [LIMIT_W-1:0] r_fail_limit;
    logic [LIMIT_W-1:0] r_near_limit;
    logic [LIMIT_W-1:0] r_stop_limit;
    logic [LIMIT_W-1:0] r_slow_limit;

    // burst state
    logic [1:0]         r_state;
    logic [CNT_W-1:0]   r_pair;
    logic [CNT_W-1:0]   r_fail;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_burst_fail;
    logic               r_none;

    // result register
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_dist;
    t_zone_res          r_res;
    logic [FAILOUT_W-1:0] r_fail_out;
    logic               r_none_out;

    logic               in_beat;
    logic [CMP_W-1:0]   a_ext;
    logic [CMP_W-1:0]   b_ext;
    logic [CMP_W-1:0]   lim_ext;
    logic               pair_fail;
    logic               pair_add;
    logic [CNT_W-1:0]   n_len;
    logic [CNT_W-1:0]   n_pair;
    logic [CNT_W-1:0]   n_fail;
    logic [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]   n_good;
    logic               burst_end;

    logic               div_start;
    logic               div_done;
    logic [SUM_W-1:0]   div_quot;

    logic [DIST_W-1:0]  zone_dist;
    t_zone_res          zone_res;
    logic               out_free;
    logic               commit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppb        <= RST_PAIRS_PER_BURST;
            r_fail_limit <= RST_FAIL_LIMIT;
            r_near_limit <= RST_NEAR_LIMIT;
            r_stop_limit <= RST_STOP_LIMIT;
            r_slow_limit <= RST_SLOW_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAIRS_PER_BURST: r_ppb        <= i_cfg_data[PPB_W-1:0];
                CFG_FAIL_LIMIT:      r_fail_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_NEAR_LIMIT:      r_near_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_STOP_LIMIT:      r_stop_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SLOW_LIMIT:      r_slow_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_beat    = i_in_valid && !o_in_stall;

    always_comb begin
        a_ext     = CMP_W'(i_echo_ticks_a);
        b_ext     = CMP_W'(i_echo_ticks_b);
        lim_ext   = CMP_W'(r_fail_limit);
        pair_fail = (a_ext > lim_ext) || (b_ext > lim_ext);
        // a width equal to the limit neither fails nor adds
        pair_add  = !pair_fail && (a_ext < lim_ext) && (b_ext < lim_ext);

        if (r_ppb == '0) begin
            n_len = CNT_W'(1);
        end else if (int'(r_ppb) > MAX_PAIRS) begin
            n_len = CNT_W'(MAX_PAIRS);
        end else begin
            n_len = CNT_W'(r_ppb);
        end

        n_pair = r_pair + 1'b1;
        n_fail = pair_fail ? r_fail + 1'b1 : r_fail;
        n_sum  = pair_add ? r_sum + SUM_W'(a_ext[LIMIT_W-1:0])
                              + SUM_W'(b_ext[LIMIT_W-1:0])
                          : r_sum;
        n_good    = (n_fail >= n_len) ? '0 : n_len - n_fail;
        burst_end = (n_pair >= n_len);
        div_start = in_beat && burst_end && (n_good != '0);
    end

    urz_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  ({n_good, 1'b0}),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        if (r_none) begin
            zone_dist = '0;
        end else if (div_quot > SUM_W'(DIST_MAX)) begin
            zone_dist = DIST_MAX;
        end else begin
            zone_dist = div_quot[DIST_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_ZONE) && out_free;

    urz_classify u_cls (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dist       (zone_dist),
        .i_near_limit (r_near_limit),
        .i_stop_limit (r_stop_limit),
        .i_slow_limit (r_slow_limit),
        .i_commit     (commit),
        .o_res        (zone_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pair  <= '0;
            r_fail  <= '0;
            r_sum   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (burst_end) begin
                            r_pair  <= '0;
                            r_fail  <= '0;
                            r_sum   <= '0;
                            r_state <= (n_good == '0) ? S_ZONE : S_DIV;
                        end else begin
                            r_pair <= n_pair;
                            r_fail <= n_fail;
                            r_sum  <= n_sum;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_ZONE;
                    end
                end
                S_ZONE: begin
                    // hold until the result register is free
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && burst_end) begin
            r_burst_fail <= n_fail;
            r_none       <= (n_good == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_dist     <= zone_dist;
            r_res      <= zone_res;
            r_fail_out <= FAILOUT_W'(r_burst_fail);
            r_none_out <= r_none;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_distance_cm   = r_dist;
    assign o_zone          = r_res.zone;
    assign o_drive_command = r_res.cmd;
    assign o_red_led       = r_res.red;
    assign o_green_led     = r_res.green;
    assign o_failed_pairs  = r_fail_out;
    assign o_all_failed    = r_none_out;

endmodule

/* rtl/urz_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urz_divider
// Restoring divider, one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module urz_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [urz_pkg::SUM_W-1:0]   i_dividend,
    input  logic [urz_pkg::DIV_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [urz_pkg::SUM_W-1:0]   o_quotient
);
    import urz_pkg::*;

    logic [SUM_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0]    n_trial;
    logic              n_ge;
    logic [DIV_W:0]    n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[SUM_W-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift dividend out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/urz_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urz_classify
// Sorts a distance into one of four zones and keeps the LED levels.
// ----------------------------------------------------------------------------
module urz_classify (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [urz_pkg::DIST_W-1:0]    i_dist,
    input  logic [urz_pkg::LIMIT_W-1:0]   i_near_limit,
    input  logic [urz_pkg::LIMIT_W-1:0]   i_stop_limit,
    input  logic [urz_pkg::LIMIT_W-1:0]   i_slow_limit,
    input  logic                          i_commit,
    output urz_pkg::t_zone_res            o_res
);
    import urz_pkg::*;

    logic r_red;
    logic r_green;

    // first test that holds decides the zone
    always_comb begin
        if (i_dist < i_near_limit) begin
            o_res.zone  = ZONE_NEAR;
            o_res.cmd   = CMD_STOP;
            o_res.red   = 1'b1;
            o_res.green = 1'b0;
        end else if (i_dist < i_stop_limit) begin
            o_res.zone  = ZONE_STOP;
            o_res.cmd   = CMD_STOP;
            o_res.red   = ~r_red;
            o_res.green = 1'b0;
        end else if (i_dist < i_slow_limit) begin
            o_res.zone  = ZONE_SLOW;
            o_res.cmd   = CMD_SLOW;
            o_res.red   = 1'b0;
            o_res.green = ~r_green;
        end else begin
            o_res.zone  = ZONE_CLEAR;
            o_res.cmd   = CMD_GO;
            o_res.red   = 1'b0;
            o_res.green = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= 1'b1;
            r_green <= 1'b1;
        end else if (i_commit) begin
            r_red   <= o_res.red;
            r_green <= o_res.green;
        end
    end

endmodule
